// ===== rtl/core/siim_pkg.sv =====
// Shared constants and the command and status types between controller and datapath of the sorted interval table.
package siim_pkg;

    // Default sizing of the interval table.
    localparam int MAX_INTERVALS_DEF = 16;
    localparam int BOUND_WIDTH_DEF   = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming word and restart the scan
        logic step;    // one scan step: place the new interval or handle one stored entry of the old table
        logic finish;  // place a pending interval and commit the new table unless it overflows
        logic emit;    // the table dump is in progress
        logic take;    // the current result word is being taken downstream
    } siim_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every entry of the old table has been visited
        logic last;       // the current result word is the final one of the dump
    } siim_sts_t;

endpackage

// ===== rtl/core/siim_ctrl.sv =====
// Sequencing state machine for the sorted interval table.
module siim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  siim_pkg::siim_sts_t sts,
    output siim_pkg::siim_cmd_t cmd
);
    import siim_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Handshake outputs follow the state alone.
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Commands to the datapath.
    always_comb
    begin
        cmd.load   = in_valid && (state_reg == ST_IDLE);
        cmd.step   = (state_reg == ST_SCAN) && !sts.scan_done;
        cmd.finish = (state_reg == ST_SCAN) && sts.scan_done;
        cmd.emit   = (state_reg == ST_EMIT);
        cmd.take   = (state_reg == ST_EMIT) && !out_stall;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/siim_dp.sv =====
// Datapath of the sorted interval table: double-buffered table memory, scan and dump.
module siim_dp #(
    parameter int MAX_INTERVALS = siim_pkg::MAX_INTERVALS_DEF,
    parameter int BOUND_WIDTH   = siim_pkg::BOUND_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  siim_pkg::siim_cmd_t           cmd,
    output siim_pkg::siim_sts_t           sts,
    input  logic signed [BOUND_WIDTH-1:0] new_lower,
    input  logic signed [BOUND_WIDTH-1:0] new_upper,
    output logic signed [BOUND_WIDTH-1:0] out_lower,
    output logic signed [BOUND_WIDTH-1:0] out_upper,
    output logic                          last_entry,
    output logic                          overflow
);
    import siim_pkg::*;

    localparam int IW        = $clog2(MAX_INTERVALS);
    localparam int CW        = $clog2(MAX_INTERVALS + 2);
    localparam int AW        = IW + 1;
    localparam int MEM_DEPTH = 1 << AW;

    // Two table halves; bank_reg selects the live one, the other receives the rebuild.
    logic [BOUND_WIDTH-1:0] mem_lower [MEM_DEPTH];
    logic [BOUND_WIDTH-1:0] mem_upper [MEM_DEPTH];

    logic                   bank_reg,   bank_next;
    logic [CW-1:0]          cnt_reg,    cnt_next;
    logic [CW-1:0]          i_reg,      i_next;
    logic [CW-1:0]          n_reg,      n_next;
    logic [CW-1:0]          e_reg,      e_next;
    logic                   placed_reg, placed_next;
    logic                   ovf_reg,    ovf_next;
    logic [BOUND_WIDTH-1:0] tl_reg,     tl_next;
    logic [BOUND_WIDTH-1:0] tu_reg,     tu_next;
    logic [BOUND_WIDTH-1:0] rd_lower_reg;
    logic [BOUND_WIDTH-1:0] rd_upper_reg;

    logic                   wr_en;
    logic                   wr_ok;
    logic [BOUND_WIDTH-1:0] wr_lower;
    logic [BOUND_WIDTH-1:0] wr_upper;
    logic [AW-1:0]          wr_addr;
    logic [CW-1:0]          rd_idx;
    logic [AW-1:0]          rd_addr;
    logic [CW-1:0]          n_fin;
    logic [BOUND_WIDTH-1:0] el;
    logic [BOUND_WIDTH-1:0] eu;

    assign el = rd_lower_reg;
    assign eu = rd_upper_reg;

    // Status to the controller.
    assign sts.scan_done = (i_reg == cnt_reg);
    assign sts.last      = last_entry;

    // Result word straight from the registered memory read.
    assign out_lower  = $signed(rd_lower_reg);
    assign out_upper  = $signed(rd_upper_reg);
    assign last_entry = (CW'(e_reg + 1'b1) == cnt_reg);
    assign overflow   = ovf_reg;

    // Scan, merge and commit logic.
    always_comb
    begin
        bank_next   = bank_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        e_next      = e_reg;
        placed_next = placed_reg;
        ovf_next    = ovf_reg;
        tl_next     = tl_reg;
        tu_next     = tu_reg;
        wr_en       = 1'b0;
        wr_lower    = el;
        wr_upper    = eu;
        n_fin       = CW'(n_reg + CW'(!placed_reg));

        if (cmd.load)
        begin
            tl_next     = new_lower;
            tu_next     = new_upper;
            i_next      = '0;
            n_next      = '0;
            e_next      = '0;
            placed_next = 1'b0;
        end

        if (cmd.step)
        begin
            priority if (placed_reg)
            begin
                // Past the insertion point: copy the entry across.
                wr_en  = 1'b1;
                n_next = CW'(n_reg + 1'b1);
                i_next = CW'(i_reg + 1'b1);
            end
            else if ($signed(tu_reg) < $signed(el))
            begin
                // Entry lies wholly above: write the new interval, revisit the entry.
                wr_en       = 1'b1;
                wr_lower    = tl_reg;
                wr_upper    = tu_reg;
                n_next      = CW'(n_reg + 1'b1);
                placed_next = 1'b1;
            end
            else if ($signed(eu) < $signed(tl_reg))
            begin
                // Entry lies wholly below: keep it.
                wr_en  = 1'b1;
                n_next = CW'(n_reg + 1'b1);
                i_next = CW'(i_reg + 1'b1);
            end
            else
            begin
                // Overlapping or touching: absorb the entry.
                if ($signed(el) < $signed(tl_reg))
                begin
                    tl_next = el;
                end
                if ($signed(tu_reg) < $signed(eu))
                begin
                    tu_next = eu;
                end
                i_next = CW'(i_reg + 1'b1);
            end
        end

        if (cmd.finish)
        begin
            // Append the interval if nothing lay above it, then commit unless full.
            if (!placed_reg)
            begin
                wr_en    = 1'b1;
                wr_lower = tl_reg;
                wr_upper = tu_reg;
            end
            n_next   = n_fin;
            ovf_next = (n_fin > CW'(MAX_INTERVALS));
            if (!(n_fin > CW'(MAX_INTERVALS)))
            begin
                bank_next = !bank_reg;
                cnt_next  = n_fin;
            end
        end

        if (cmd.take)
        begin
            e_next = CW'(e_reg + 1'b1);
        end
    end

    // Memory addressing: writes go to the spare half, reads are addressed with the next index.
    assign wr_ok   = wr_en && (n_reg < CW'(MAX_INTERVALS));
    assign wr_addr = {!bank_reg, n_reg[IW-1:0]};

    always_comb
    begin
        priority if (cmd.step)
        begin
            rd_idx = i_next;
        end
        else if (cmd.emit)
        begin
            rd_idx = e_next;
        end
        else
        begin
            rd_idx = '0;
        end
    end

    assign rd_addr = {bank_reg, rd_idx[IW-1:0]};

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_lower[wr_addr] <= wr_lower;
            mem_upper[wr_addr] <= wr_upper;
        end
        rd_lower_reg <= mem_lower[rd_addr];
        rd_upper_reg <= mem_upper[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= 1'b0;
            cnt_reg    <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            e_reg      <= '0;
            placed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            bank_reg   <= bank_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            n_reg      <= n_next;
            e_reg      <= e_next;
            placed_reg <= placed_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Working interval bounds.
    always_ff @(posedge clk)
    begin
        tl_reg <= tl_next;
        tu_reg <= tu_next;
    end

endmodule

// ===== rtl/core/sorted_interval_insert_merge_top.sv =====
// Operation: the scan visits each stored entry in turn, with one more step if the new
// interval is placed before an entry, then commits the new table; a load state reads the
// first entry, and the dump then shows one entry at a time, held while out_stall is high.
// A new input word is taken only once the final word of the dump has been taken.
// Reset: the entry count, table bank and state machine clear at once; memory is not cleared.
module sorted_interval_insert_merge_top #(
    parameter int MAX_INTERVALS = siim_pkg::MAX_INTERVALS_DEF,
    parameter int BOUND_WIDTH   = siim_pkg::BOUND_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [BOUND_WIDTH-1:0] new_lower,
    input  logic signed [BOUND_WIDTH-1:0] new_upper,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [BOUND_WIDTH-1:0] out_lower,
    output logic signed [BOUND_WIDTH-1:0] out_upper,
    output logic                          last_entry,
    output logic                          overflow
);
    import siim_pkg::*;

    siim_cmd_t cmd;
    siim_sts_t sts;

    // Sequencer.
    siim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table storage and interval arithmetic.
    siim_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .BOUND_WIDTH   (BOUND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .new_lower  (new_lower),
        .new_upper  (new_upper),
        .out_lower  (out_lower),
        .out_upper  (out_upper),
        .last_entry (last_entry),
        .overflow   (overflow)
    );

endmodule

// ===== rtl/core/siim_checker.sv =====
// Port-level checks for the sorted interval table, bound to the top level.
module siim_checker #(
    parameter int BOUND_WIDTH = siim_pkg::BOUND_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [BOUND_WIDTH-1:0] out_lower,
    input logic signed [BOUND_WIDTH-1:0] out_upper,
    input logic                          last_entry,
    input logic                          overflow
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_lower) && $stable(out_upper)
            && $stable(last_entry) && $stable(overflow))
    else $error("stalled result word changed");

    // No new word is taken while a dump is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
    else $error("input taken during a table dump");

    // The scan always separates an accepted word from its first result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
    else $error("result shown in the cycle after an input word");

    // A dump keeps going until its final word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_entry |=> out_valid)
    else $error("dump ended before the final word");

    // Taking the final word frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_entry |=> !in_stall && !out_valid)
    else $error("block not idle after the final word");

endmodule

bind sorted_interval_insert_merge_top siim_checker #(
    .BOUND_WIDTH (BOUND_WIDTH)
) u_siim_checker (.*);
